// ===== rtl/core/hcp_pkg.sv =====
`timescale 1ns / 1ps

package hcp_pkg;

  // Fixed widths of the encoder back end
  localparam int BYTE_BITS   = 8;
  localparam int PEND_BITS   = 7;
  localparam int PCNT_BITS   = 3;
  localparam int VALUE_BITS  = 32;
  localparam int LEN_BITS    = 6;
  localparam int SYM_BITS    = 8;
  localparam int TABLE_DEPTH = 256;

  // Transaction commands
  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } hcp_op_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_we;
    logic read_en;
    logic setup;
    logic emit;
    logic finalize;
    logic flush;
  } hcp_ctl_t;

endpackage

// ===== rtl/core/hcp_ctrl.sv =====
`timescale 1ns / 1ps

module hcp_ctrl
  import hcp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_cmd,
  input  logic       total_ge8,
  output logic       busy,
  output hcp_ctl_t   ctl
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SETUP = 4'b0010,
    ST_EMIT  = 4'b0100,
    ST_FLUSH = 4'b1000
  } hcp_state_t;

  hcp_state_t state_r, state_nxt;
  logic       accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Sequence one transaction at a time
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (hcp_op_t'(in_cmd))
            CMD_LOAD:   ctl.load_we = 1'b1;
            CMD_ENCODE: begin
              ctl.read_en = 1'b1;
              state_nxt   = ST_SETUP;
            end
            CMD_FLUSH:  state_nxt = ST_FLUSH;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SETUP: begin
        ctl.setup = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (total_ge8) begin
          ctl.emit = 1'b1;
        end else begin
          ctl.finalize = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        ctl.flush = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/hcp_datapath.sv =====
`timescale 1ns / 1ps

module hcp_datapath
  import hcp_pkg::*;
#(
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hcp_ctl_t              ctl,
  input  logic [SYM_BITS-1:0]   in_symbol,
  input  logic [VALUE_BITS-1:0] in_code_value,
  input  logic [LEN_BITS-1:0]   in_code_len,
  output logic                  total_ge8,
  output logic                  out_valid,
  output logic [BYTE_BITS-1:0]  out_byte,
  output logic                  out_last
);

  localparam int CAP  = (MAX_CODE_LEN < VALUE_BITS) ? MAX_CODE_LEN : VALUE_BITS;
  localparam int LW   = $clog2(CAP + 1);
  localparam int EW   = LW + CAP;
  localparam int ACCW = CAP + PEND_BITS;
  localparam int TW   = $clog2(ACCW + 1);

  logic [EW-1:0]        mem [TABLE_DEPTH];
  logic [EW-1:0]        rd_r;
  logic [LW-1:0]        len_sat;
  logic [CAP-1:0]       val_masked;
  logic [LW-1:0]        rd_len;
  logic [CAP-1:0]       rd_val;

  logic [ACCW-1:0]      acc_r, acc_nxt;
  logic [TW-1:0]        total_r, total_nxt;
  logic [PEND_BITS-1:0] pend_bits_r, pend_bits_nxt;
  logic [PCNT_BITS-1:0] pend_cnt_r, pend_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [BYTE_BITS-1:0] out_byte_r, out_byte_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [TW-1:0]        emit_shamt;
  logic [PCNT_BITS-1:0] flush_shamt;
  logic [PEND_BITS-1:0] pend_mask;

  // Saturate the length and drop value bits above it
  assign len_sat = (in_code_len > LEN_BITS'(CAP)) ? LW'(CAP) : LW'(in_code_len);

  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      val_masked[i] = in_code_value[i] & (i < int'(len_sat));
    end
  end

  // Code table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.load_we) begin
      mem[in_symbol] <= {len_sat, val_masked};
    end
    if (ctl.read_en) begin
      rd_r <= mem[in_symbol];
    end
  end

  assign rd_len = rd_r[EW-1:CAP];
  assign rd_val = rd_r[CAP-1:0];

  assign total_ge8   = (total_r >= TW'(BYTE_BITS));
  assign emit_shamt  = total_r - TW'(BYTE_BITS);
  assign flush_shamt = PCNT_BITS'(4'(BYTE_BITS) - {1'b0, pend_cnt_r});
  assign pend_mask   = ~({PEND_BITS{1'b1}} << total_r[PCNT_BITS-1:0]);

  // Append the code, peel bytes from the top, keep the remainder, pad it on flush
  always_comb begin
    acc_nxt       = acc_r;
    total_nxt     = total_r;
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    out_valid_nxt = 1'b0;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;

    if (ctl.setup) begin
      acc_nxt   = (ACCW'(pend_bits_r) << rd_len) | ACCW'(rd_val);
      total_nxt = TW'(pend_cnt_r) + TW'(rd_len);
    end

    if (ctl.emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = BYTE_BITS'(acc_r >> emit_shamt);
      out_last_nxt  = (total_r < TW'(2 * BYTE_BITS));
      total_nxt     = emit_shamt;
    end

    if (ctl.finalize) begin
      pend_bits_nxt = acc_r[PEND_BITS-1:0] & pend_mask;
      pend_cnt_nxt  = total_r[PCNT_BITS-1:0];
    end

    if (ctl.flush && (pend_cnt_r != '0)) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = {1'b0, pend_bits_r} << flush_shamt;
      out_last_nxt  = 1'b1;
      pend_bits_nxt = '0;
      pend_cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      total_r     <= total_nxt;
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

// ===== rtl/core/huffman_code_packer.sv =====
`timescale 1ns / 1ps

// Huffman code packer. A load transaction writes one symbol's code word and
// length into a 256-entry code table; busy stays low. An encode transaction
// reads the table (one registered read), appends the code MSB-first to the
// pending bits and shifts out one byte per cycle, holding busy while it runs and
// producing 0 to 4 bytes for codes of up to 32 bits. A flush transaction
// holds busy while it runs and emits the zero-padded
// pending bits as a final byte, if any are pending. Bytes appear on out_byte
// one cycle after they are formed, one per clock while out_valid is high, and
// the receiver must take each one in that cycle: there is no backpressure.
// out_last marks the final byte of each transaction. Encoding a symbol whose
// entry was never loaded returns undefined bytes.
module huffman_code_packer
  import hcp_pkg::*;
#(
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_cmd,
  input  logic [SYM_BITS-1:0]   in_symbol,
  input  logic [VALUE_BITS-1:0] in_code_value,
  input  logic [LEN_BITS-1:0]   in_code_len,
  output logic                  out_valid,
  output logic [BYTE_BITS-1:0]  out_byte,
  output logic                  out_last
);

  hcp_ctl_t ctl;
  logic     total_ge8;

  hcp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_cmd    (in_cmd),
    .total_ge8 (total_ge8),
    .busy      (busy),
    .ctl       (ctl)
  );

  hcp_datapath #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .in_symbol     (in_symbol),
    .in_code_value (in_code_value),
    .in_code_len   (in_code_len),
    .total_ge8     (total_ge8),
    .out_valid     (out_valid),
    .out_byte      (out_byte),
    .out_last      (out_last)
  );

endmodule

// ===== rtl/core/hcp_checker.sv =====
`timescale 1ns / 1ps

module hcp_checker
  import hcp_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_cmd,
  input logic       out_valid,
  input logic       out_last
);

  // Reset leaves the block idle and silent
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

  // Bytes of one transaction come out back to back until the last one
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("gap inside an output burst");

  // A table load completes in its accept cycle
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_cmd == CMD_LOAD |=> !busy)
    else $error("load held the block busy");

  // Encode and flush occupy the block
  a_work: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_cmd == CMD_ENCODE || in_cmd == CMD_FLUSH) |=> busy)
    else $error("encode or flush not started");

endmodule

bind huffman_code_packer hcp_checker u_hcp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_cmd    (in_cmd),
  .out_valid (out_valid),
  .out_last  (out_last)
);

// ===== tb/sv/tb_huffman_code_packer.sv =====
`timescale 1ns / 1ps

module tb_huffman_code_packer;
  import hcp_pkg::*;

  localparam int MAX_CODE_LEN = 32;
  localparam int CYCLE_LIMIT  = 50000;
  localparam int NUM_RANDOM   = 248;
  // Command code the block must ignore
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [BYTE_BITS-1:0] data;
    logic                 is_last;
  } expected_byte_t;

  // Code table, bit accumulator and the bytes still owed by the block
  class byte_stream_checker;
    logic [VALUE_BITS-1:0] code_val [TABLE_DEPTH];
    int                    code_len [TABLE_DEPTH];
    logic [PEND_BITS-1:0]  acc_bits;
    int                    acc_count;
    expected_byte_t        owed_bytes [$];
    int                    mismatches;

    function new();
      acc_bits   = '0;
      acc_count  = 0;
      mismatches = 0;
      foreach (code_val[i]) begin
        code_val[i] = '0;
        code_len[i] = 0;
      end
    endfunction

    // Update the table or accumulator for one accepted transaction
    function void note_cmd(logic [1:0] cmd, logic [SYM_BITS-1:0] sym,
                           logic [VALUE_BITS-1:0] val, logic [LEN_BITS-1:0] len);
      int             cap;
      int             n_len;
      int             total;
      logic [63:0]    acc;
      logic [15:0]    padded;
      expected_byte_t eb;
      cap = (MAX_CODE_LEN < VALUE_BITS) ? MAX_CODE_LEN : VALUE_BITS;
      case (cmd)
        CMD_LOAD: begin
          // Saturate the length, drop value bits above it
          n_len = (int'(len) > cap) ? cap : int'(len);
          code_len[sym] = n_len;
          code_val[sym] = VALUE_BITS'(64'(val) & ((64'd1 << n_len) - 64'd1));
        end
        CMD_ENCODE: begin
          n_len = code_len[sym];
          total = acc_count + n_len;
          acc   = (64'(acc_bits) << n_len) | 64'(code_val[sym]);
          // Emit every completed byte, earliest bit first
          while (total >= BYTE_BITS) begin
            eb.data    = BYTE_BITS'(acc >> (total - BYTE_BITS));
            total      = total - BYTE_BITS;
            eb.is_last = (total < BYTE_BITS);
            owed_bytes = {owed_bytes, eb};
          end
          acc_count = total;
          acc_bits  = PEND_BITS'(acc & ((64'd1 << total) - 64'd1));
        end
        CMD_FLUSH: begin
          // Pad the pending bits with zeros into one final byte
          if (acc_count != 0) begin
            padded     = 16'(acc_bits) << (BYTE_BITS - acc_count);
            eb.data    = padded[BYTE_BITS-1:0];
            eb.is_last = 1'b1;
            owed_bytes = {owed_bytes, eb};
            acc_bits   = '0;
            acc_count  = 0;
          end
        end
        default: begin
        end
      endcase
    endfunction

    // Compare one output byte with the oldest owed byte
    function void check_byte(logic [BYTE_BITS-1:0] data, logic is_last);
      expected_byte_t eb;
      if (owed_bytes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected byte %02h (last %b), none expected", $time, data, is_last);
        return;
      end
      eb = owed_bytes.pop_front();
      if (data !== eb.data) begin
        mismatches++;
        $display("%0t: out_byte expected %02h, actual %02h", $time, eb.data, data);
      end
      if (is_last !== eb.is_last) begin
        mismatches++;
        $display("%0t: out_last expected %b, actual %b", $time, eb.is_last, is_last);
      end
    endfunction
  endclass

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  start         = 1'b0;
  logic [1:0]            in_cmd        = '0;
  logic [SYM_BITS-1:0]   in_symbol     = '0;
  logic [VALUE_BITS-1:0] in_code_value = '0;
  logic [LEN_BITS-1:0]   in_code_len   = '0;
  logic                  busy;
  logic                  out_valid;
  logic [BYTE_BITS-1:0]  out_byte;
  logic                  out_last;

  byte_stream_checker    stream = new();
  bit                    sender_idles = 1'b1;
  bit                    loaded [TABLE_DEPTH];
  logic [SYM_BITS-1:0]   loaded_syms [$];
  int                    cycles = 0;

  huffman_code_packer #(
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_symbol    (in_symbol),
    .in_code_value(in_code_value),
    .in_code_len  (in_code_len),
    .out_valid    (out_valid),
    .out_byte     (out_byte),
    .out_last     (out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Check every strobed byte
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      stream.check_byte(out_byte, out_last);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_huffman_code_packer: done, errors");
      $finish;
    end
  end

  // Present one transaction, hold it until accepted, then maybe idle
  task automatic issue(input logic [1:0] cmd, input logic [SYM_BITS-1:0] sym,
                       input logic [VALUE_BITS-1:0] val, input logic [LEN_BITS-1:0] len);
    start         <= 1'b1;
    in_cmd        <= cmd;
    in_symbol     <= sym;
    in_code_value <= val;
    in_code_len   <= len;
    do @(posedge clk); while (busy !== 1'b0);
    stream.note_cmd(cmd, sym, val, len);
    if (cmd == CMD_LOAD && !loaded[sym]) begin
      loaded[sym] = 1'b1;
      loaded_syms = {loaded_syms, sym};
    end
    if (sender_idles && $urandom_range(99) < 22) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  initial begin
    int                    pick;
    logic [SYM_BITS-1:0]   sym;
    logic [LEN_BITS-1:0]   len;
    foreach (loaded[i]) loaded[i] = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: table extremes, odd lengths, byte boundaries, flushes
    issue(CMD_FLUSH,   8'h00, 32'h0000_0000, 6'd0);   // nothing pending
    issue(CMD_LOAD,    8'h00, 32'h0000_0001, 6'd1);
    issue(CMD_LOAD,    8'hFF, 32'hFFFF_FFFF, 6'd32);
    issue(CMD_LOAD,    8'h01, 32'h0000_0000, 6'd0);   // zero length
    issue(CMD_LOAD,    8'h02, 32'hA5C3_96E1, 6'd63);  // saturated length
    issue(CMD_LOAD,    8'h03, 32'hFFFF_FFE5, 6'd5);   // stray high value bits
    issue(CMD_LOAD,    8'h04, 32'h0000_0000, 6'd8);
    issue(CMD_LOAD,    8'h05, 32'h1234_5678, 6'd33);
    issue(CMD_LOAD,    8'h06, 32'h0000_0055, 6'd7);
    issue(CMD_ENCODE,  8'h00, 32'h0000_0000, 6'd0);
    issue(CMD_ENCODE,  8'hFF, 32'h0000_0000, 6'd0);   // four bytes out
    issue(CMD_ENCODE,  8'h01, 32'h0000_0000, 6'd0);   // appends nothing
    issue(CMD_ENCODE,  8'h06, 32'h0000_0000, 6'd0);   // lands on a byte boundary
    issue(CMD_ENCODE,  8'h03, 32'h0000_0000, 6'd0);
    issue(CMD_FLUSH,   8'h00, 32'h0000_0000, 6'd0);
    issue(CMD_FLUSH,   8'h00, 32'h0000_0000, 6'd0);   // nothing pending
    issue(CMD_ENCODE,  8'h06, 32'h0000_0000, 6'd0);
    issue(CMD_ENCODE,  8'h02, 32'h0000_0000, 6'd0);   // seven pending plus 32
    issue(CMD_ENCODE,  8'h05, 32'h0000_0000, 6'd0);
    issue(CMD_UNKNOWN, 8'hFF, 32'hFFFF_FFFF, 6'h3F);  // ignored
    issue(CMD_ENCODE,  8'h04, 32'h0000_0000, 6'd0);
    issue(CMD_FLUSH,   8'h00, 32'h0000_0000, 6'd0);

    // Random: mostly encodes of loaded symbols, with reloads and flushes
    for (int i = 0; i < NUM_RANDOM; i++) begin
      sender_idles = !(i >= 120 && i < 200);
      pick = $urandom_range(99);
      if (pick < 22) begin
        sym = SYM_BITS'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 75) len = LEN_BITS'($urandom_range(1, 12));
        else if (pick < 93) len = LEN_BITS'($urandom_range(13, 32));
        else if (pick < 96) len = '0;
        else len = LEN_BITS'($urandom_range(33, 63));
        issue(CMD_LOAD, sym, $urandom(), len);
      end else if (pick < 80) begin
        sym = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
        issue(CMD_ENCODE, sym, $urandom(), LEN_BITS'($urandom_range(63)));
      end else if (pick < 96) begin
        issue(CMD_FLUSH, SYM_BITS'($urandom_range(255)), $urandom(),
              LEN_BITS'($urandom_range(63)));
      end else begin
        issue(CMD_UNKNOWN, SYM_BITS'($urandom_range(255)), $urandom(),
              LEN_BITS'($urandom_range(63)));
      end
    end
    start <= 1'b0;

    // Drain the owed bytes, then give the block time for stray output
    while (stream.owed_bytes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (stream.mismatches == 0 && stream.owed_bytes.size() == 0) begin
      $display("tb_huffman_code_packer: done, clean");
    end else begin
      $display("tb_huffman_code_packer: done, errors");
    end
    $finish;
  end

endmodule
